### hw/rtl/assert_macros.svh
// Assertion macros used by the transcoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CTU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define CTU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CTU_ASSERT(lbl, clk, rstn, prop)
`define CTU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/ctu_pkg.sv
// Types and constants of the charset transcoder.
package ctu_pkg;

  localparam logic [1:0] ENC_UTF8   = 2'd0;
  localparam logic [1:0] ENC_LATIN1 = 2'd1;
  localparam logic [1:0] ENC_UCS4   = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_ORDER  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNENC   = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam int CP_W = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] source_code;
    logic [1:0] target_code;
    logic       ucs4_big_endian;
  } cfg_t;

  // Decoded character handed from front to back: an error status or a code point.
  typedef struct packed {
    logic [1:0]      status;
    logic [CP_W-1:0] cp;
  } job_t;

endpackage

### hw/rtl/charset_transcoder_unit.sv
// Charset transcoder top level: config registers, front decoder, queue, back encoder.
//
// Bytes enter through a queue-style port and are decoded from UTF-8, Latin-1
// or UCS-4 into code points, then re-encoded as UTF-8, Latin-1 or UCS-4 bytes,
// one result byte per transaction, each tagged with a status and run_last on
// the final result of its input byte. The front decoder accepts one byte per
// cycle while the character queue (QUEUE_DEPTH entries) has room; the back
// encoder emits one output byte per cycle while the output is free or taken;
// a character yields 1 to 4 result bytes; an upper-half Latin-1 character
// yields two when encoded as UTF-8. A result passes through the queue, the
// job register and the output register. After an error the
// block drops input silently until a byte with in_last. Config writes are
// accepted every cycle; indexes beyond the register list are ignored.
module charset_transcoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  ctu_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output ctu_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data
);

  ctu_pkg::cfg_t cfg_r, cfg_nxt;
  ctu_pkg::job_t fe_job, q_head;
  logic          fe_push, q_full, q_valid, q_pop;
  logic          accept, out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign full      = q_full;
  assign empty     = !out_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ctu_pkg::REG_SOURCE: cfg_nxt.source_code     = cfg_data;
        ctu_pkg::REG_TARGET: cfg_nxt.target_code     = cfg_data;
        ctu_pkg::REG_ORDER:  cfg_nxt.ucs4_big_endian = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  ctu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .item     (in_data),
    .job_push (fe_push),
    .job      (fe_job)
  );

  ctu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_data (fe_job),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  ctu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_item  (out_data),
    .out_valid (out_valid),
    .out_take  (pop)
  );

endmodule

### hw/rtl/ctu_front.sv
// Front end: decodes input bytes into code points and classifies errors.
module ctu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ctu_pkg::cfg_t     cfg,
  input  logic              accept,
  input  ctu_pkg::in_item_t item,
  output logic              job_push,
  output ctu_pkg::job_t     job
);

  logic [31:0] accum_r, accum_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        halt_r, halt_nxt;

  logic [31:0] acc;
  logic [1:0]  pend;
  logic        have;
  logic [1:0]  err;
  logic [7:0]  b;

  always_comb begin
    b    = item.in_byte;
    acc  = accum_r;
    pend = pend_r;
    have = 1'b0;
    err  = ctu_pkg::ST_OK;
    job_push  = 1'b0;
    job       = '0;
    accum_nxt = accum_r;
    pend_nxt  = pend_r;
    halt_nxt  = halt_r;

    if (halt_r) begin
      if (item.in_last) begin
        acc  = '0;
        pend = '0;
      end
      if (accept) begin
        accum_nxt = acc;
        pend_nxt  = pend;
        halt_nxt  = !item.in_last;
      end
    end else begin
      case (cfg.source_code)
        ctu_pkg::ENC_UCS4: begin
          if (pend == 2'd0) begin
            acc  = {24'd0, b};
            pend = 2'd3;
          end else begin
            if (cfg.ucs4_big_endian) begin
              acc = {acc[23:0], b};
            end else begin
              case (pend)
                2'd3:    acc = acc | {16'd0, b, 8'd0};
                2'd2:    acc = acc | {8'd0, b, 16'd0};
                default: acc = acc | {b, 24'd0};
              endcase
            end
            pend = pend - 2'd1;
            have = (pend == 2'd0);
          end
        end
        ctu_pkg::ENC_LATIN1: begin
          acc  = {24'd0, b};
          pend = 2'd0;
          have = 1'b1;
        end
        default: begin
          if (pend == 2'd0) begin
            if (b <= 8'h7f) begin
              acc  = {24'd0, b};
              have = 1'b1;
            end else if (b <= 8'hdf) begin
              acc  = {27'd0, b[4:0]};
              pend = 2'd1;
            end else if (b <= 8'hef) begin
              acc  = {28'd0, b[3:0]};
              pend = 2'd2;
            end else if (b <= 8'hf7) begin
              acc  = {29'd0, b[2:0]};
              pend = 2'd3;
            end else begin
              err = ctu_pkg::ST_INVALID;
            end
          end else begin
            acc  = {acc[25:0], b[5:0]};
            pend = pend - 2'd1;
            have = (pend == 2'd0);
          end
        end
      endcase

      if (err == ctu_pkg::ST_OK && !have && pend != 2'd0 && item.in_last) begin
        err = ctu_pkg::ST_INVALID;
      end

      if (err == ctu_pkg::ST_OK && have) begin
        if (acc == 32'd0) begin
          err = ctu_pkg::ST_ZERO;
        end else if (cfg.target_code == ctu_pkg::ENC_LATIN1) begin
          if (acc > 32'h0000_00ff) err = ctu_pkg::ST_UNENC;
        end else if (acc > 32'h001f_ffff) begin
          err = ctu_pkg::ST_UNENC;
        end
      end

      job.status = err;
      job.cp     = (err == ctu_pkg::ST_OK) ? acc[ctu_pkg::CP_W-1:0] : '0;

      if (accept) begin
        job_push = have || (err != ctu_pkg::ST_OK);
        if (job_push) begin
          accum_nxt = '0;
          pend_nxt  = '0;
          halt_nxt  = (err != ctu_pkg::ST_OK) && !item.in_last;
        end else begin
          accum_nxt = acc;
          pend_nxt  = pend;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      pend_r  <= '0;
      halt_r  <= 1'b0;
    end else begin
      accum_r <= accum_nxt;
      pend_r  <= pend_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

### hw/rtl/ctu_queue.sv
// Short queue of decoded characters between front and back.
module ctu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ctu_pkg::job_t push_data,
  output logic          q_full,
  input  logic          q_pop,
  output logic          q_valid,
  output ctu_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  ctu_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == DEPTH_C);
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + PW'(1);
    if (q_pop) rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + PW'(1);
    if (push && !q_pop) count_nxt = count_r + CW'(1);
    else if (!push && q_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/ctu_back.sv
// Back end: encodes one character into output bytes, one per cycle while the output is free or taken.
`include "assert_macros.svh"

module ctu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ctu_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  ctu_pkg::job_t      head,
  output logic               q_pop,
  output ctu_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_take
);

  ctu_pkg::job_t      job_r, job_nxt;
  logic               job_v_r, job_v_nxt;
  logic [1:0]         idx_r, idx_nxt;
  ctu_pkg::out_item_t out_r, out_nxt;
  logic               ov_r, ov_nxt;

  logic [7:0]  bytes [4];
  logic [1:0]  last_idx;
  logic [31:0] cp32;
  logic        out_adv;
  logic        final_byte;

  // Encoder for the character held in job_r.
  always_comb begin
    cp32     = {{(32 - ctu_pkg::CP_W){1'b0}}, job_r.cp};
    bytes[0] = '0;
    bytes[1] = '0;
    bytes[2] = '0;
    bytes[3] = '0;
    last_idx = 2'd0;
    if (job_r.status == ctu_pkg::ST_OK) begin
      case (cfg.target_code)
        ctu_pkg::ENC_LATIN1: begin
          bytes[0] = cp32[7:0];
        end
        ctu_pkg::ENC_UCS4: begin
          last_idx = 2'd3;
          if (cfg.ucs4_big_endian) begin
            bytes[0] = cp32[31:24];
            bytes[1] = cp32[23:16];
            bytes[2] = cp32[15:8];
            bytes[3] = cp32[7:0];
          end else begin
            bytes[0] = cp32[7:0];
            bytes[1] = cp32[15:8];
            bytes[2] = cp32[23:16];
            bytes[3] = cp32[31:24];
          end
        end
        default: begin
          if (cp32 <= 32'h7f) begin
            bytes[0] = cp32[7:0];
          end else if (cp32 <= 32'h7ff) begin
            last_idx = 2'd1;
            bytes[0] = {3'b110, cp32[10:6]};
            bytes[1] = {2'b10, cp32[5:0]};
          end else if (cp32 <= 32'hffff) begin
            last_idx = 2'd2;
            bytes[0] = {4'b1110, cp32[15:12]};
            bytes[1] = {2'b10, cp32[11:6]};
            bytes[2] = {2'b10, cp32[5:0]};
          end else begin
            last_idx = 2'd3;
            bytes[0] = {5'b11110, cp32[20:18]};
            bytes[1] = {2'b10, cp32[17:12]};
            bytes[2] = {2'b10, cp32[11:6]};
            bytes[3] = {2'b10, cp32[5:0]};
          end
        end
      endcase
    end
  end

  always_comb begin
    out_adv    = !ov_r || out_take;
    final_byte = job_v_r && out_adv && (idx_r == last_idx);
    q_pop      = q_valid && (!job_v_r || final_byte);
    job_nxt    = job_r;
    job_v_nxt  = job_v_r;
    idx_nxt    = idx_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r && !out_take;

    if (job_v_r && out_adv) begin
      out_nxt.out_byte = bytes[idx_r];
      out_nxt.status   = job_r.status;
      out_nxt.run_last = (idx_r == last_idx);
      ov_nxt           = 1'b1;
      idx_nxt          = idx_r + 2'd1;
    end
    if (!job_v_r || final_byte) begin
      job_v_nxt = q_valid;
      idx_nxt   = 2'd0;
      if (q_valid) job_nxt = head;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_item  = out_r;
  assign out_valid = ov_r;

  `CTU_ASSERT_IMPL(a_err_single, clk, rst_n, job_v_r && job_r.status != ctu_pkg::ST_OK, last_idx == 2'd0)
  `CTU_ASSERT_IMPL(a_err_byte, clk, rst_n, ov_r && out_r.status != ctu_pkg::ST_OK, out_r.out_byte == 8'd0 && out_r.run_last)
  `CTU_ASSERT_IMPL(a_idx_range, clk, rst_n, job_v_r, idx_r <= last_idx)
  `CTU_ASSERT_IMPL(a_no_gap, clk, rst_n, job_v_r && !ov_r, ##1 ov_r)

endmodule
